// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top level of the lexer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ETL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ETL_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hw/rtl/etl_pkg.sv -----
// Types, character constants and helper functions of the expression token lexer.
package etl_pkg;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned MAX_TOKENS = 3;

  // Slot of each token a single source byte can cause, in output order.
  localparam int unsigned SLOT_RUN = 0;
  localparam int unsigned SLOT_SYM = 1;
  localparam int unsigned SLOT_EOF = 2;

  localparam logic [2:0] KW_LEN = 3'd5;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_VTAB    = 8'h0B;
  localparam logic [7:0] CH_FFEED   = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

  typedef enum logic [3:0] {
    TK_PRINT  = 4'd0,
    TK_IDENT  = 4'd1,
    TK_NUMBER = 4'd2,
    TK_LPAREN = 4'd3,
    TK_RPAREN = 4'd4,
    TK_PLUS   = 4'd5,
    TK_MINUS  = 4'd6,
    TK_EOF    = 4'd7,
    TK_ERROR  = 4'd8
  } token_kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_ERROR  = 2'd3
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       byte_present;
    logic       end_of_source;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]         token_kind;
    logic [FIELD_W-1:0] token_line;
    logic [FIELD_W-1:0] token_column;
    logic [FIELD_W-1:0] token_length;
    logic [7:0]         symbol_char;
    logic               last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic [MAX_TOKENS-1:0]            vld;
    out_beat_t [MAX_TOKENS-1:0]       tok;
  } tok_batch_t;

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VTAB) || (c == CH_FFEED) ||
           (c == CH_CR);
  endfunction

  // Spelling of the keyword, one character per position.
  function automatic logic [7:0] keyword_char(logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h70;
      3'd1:    ch = 8'h72;
      3'd2:    ch = 8'h69;
      3'd3:    ch = 8'h6E;
      3'd4:    ch = 8'h74;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic token_kind_e symbol_kind(logic [7:0] c);
    token_kind_e k;
    unique case (c)
      CH_LPAREN: k = TK_LPAREN;
      CH_RPAREN: k = TK_RPAREN;
      CH_PLUS:   k = TK_PLUS;
      CH_MINUS:  k = TK_MINUS;
      default:   k = TK_ERROR;
    endcase
    return k;
  endfunction

  function automatic out_beat_t make_token(token_kind_e kind, logic [FIELD_W-1:0] line,
                                           logic [FIELD_W-1:0] col,
                                           logic [FIELD_W-1:0] len, logic [7:0] ch);
    out_beat_t t;
    t.token_kind   = kind;
    t.token_line   = line;
    t.token_column = col;
    t.token_length = len;
    t.symbol_char  = ch;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

endpackage

// ----- hw/rtl/etl_scan.sv -----
// Scanner state and per-byte token logic of the expression token lexer.
module etl_scan import etl_pkg::*; #(
  parameter int unsigned CounterWidth = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  in_beat_t   beat_i,
  output tok_batch_t batch_o
);

  typedef logic [CounterWidth-1:0] cnt_t;
  localparam cnt_t CntMax = '1;
  localparam cnt_t CntOne = cnt_t'(1);

  scan_mode_e mode_q, mode_d;
  cnt_t       line_q, line_d;
  cnt_t       col_q, col_d;
  cnt_t       start_q, start_d;
  cnt_t       len_q, len_d;
  logic [2:0] kwp_q, kwp_d;
  logic       kwok_q, kwok_d;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == CntMax) ? v : v + CntOne;
  endfunction

  function automatic out_beat_t run_token(scan_mode_e m, logic ok, logic [2:0] p, cnt_t ln,
                                          cnt_t st, cnt_t n);
    token_kind_e k;
    if (m == MODE_NUMBER) begin
      k = TK_NUMBER;
    end else begin
      k = (ok && (p == KW_LEN)) ? TK_PRINT : TK_IDENT;
    end
    return make_token(k, FIELD_W'(ln), FIELD_W'(st), FIELD_W'(n), CH_NUL);
  endfunction

  always_comb begin
    logic [7:0]  c;
    logic        done;
    logic        cont;
    token_kind_e sk;
    c       = beat_i.source_byte;
    done    = beat_i.end_of_source || (beat_i.byte_present && (c == CH_NUL));
    cont    = 1'b0;
    sk      = symbol_kind(c);
    batch_o = '0;
    mode_d  = mode_q;
    line_d  = line_q;
    col_d   = col_q;
    start_d = start_q;
    len_d   = len_q;
    kwp_d   = kwp_q;
    kwok_d  = kwok_q;

    if (beat_i.byte_present && (c != CH_NUL) && (mode_q != MODE_ERROR)) begin
      if ((mode_q == MODE_IDENT) && (is_letter(c) || is_digit(c) || (c == CH_UNDER))) begin
        if (kwok_q && (kwp_q < KW_LEN) && (c == keyword_char(kwp_q))) begin
          kwp_d = kwp_q + 3'd1;
        end else begin
          kwok_d = 1'b0;
        end
        len_d = sat_inc(len_q);
        col_d = sat_inc(col_q);
        cont  = 1'b1;
      end else if ((mode_q == MODE_NUMBER) && is_digit(c)) begin
        len_d = sat_inc(len_q);
        col_d = sat_inc(col_q);
        cont  = 1'b1;
      end else if ((mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER)) begin
        // Byte ends the pending run: flush it, then treat the byte from idle.
        batch_o.vld[SLOT_RUN] = 1'b1;
        batch_o.tok[SLOT_RUN] = run_token(mode_q, kwok_q, kwp_q, line_q, start_q, len_q);
        mode_d  = MODE_IDLE;
        start_d = '0;
        len_d   = '0;
        kwp_d   = 3'd0;
        kwok_d  = 1'b1;
      end

      if (!cont) begin
        if (c == CH_NEWLINE) begin
          line_d = sat_inc(line_q);
          col_d  = CntOne;
        end else if (is_blank(c)) begin
          col_d = sat_inc(col_q);
        end else if (is_letter(c) || (c == CH_UNDER)) begin
          mode_d  = MODE_IDENT;
          start_d = col_q;
          len_d   = CntOne;
          kwok_d  = (c == keyword_char(3'd0));
          kwp_d   = (c == keyword_char(3'd0)) ? 3'd1 : 3'd0;
          col_d   = sat_inc(col_q);
        end else if (is_digit(c)) begin
          mode_d  = MODE_NUMBER;
          start_d = col_q;
          len_d   = CntOne;
          kwok_d  = 1'b1;
          kwp_d   = 3'd0;
          col_d   = sat_inc(col_q);
        end else begin
          batch_o.vld[SLOT_SYM] = 1'b1;
          batch_o.tok[SLOT_SYM] = make_token(sk, FIELD_W'(line_q), FIELD_W'(col_q),
                                             FIELD_W'(CntOne), c);
          col_d = sat_inc(col_q);
          if (sk == TK_ERROR) begin
            mode_d = MODE_ERROR;
          end
        end
      end
    end

    if (done) begin
      // A pending run here is from earlier bytes or started or extended by this byte, so
      // no symbol went out; the first slot may hold a run it ended, so use the middle one.
      if ((mode_d == MODE_IDENT) || (mode_d == MODE_NUMBER)) begin
        batch_o.vld[SLOT_SYM] = 1'b1;
        batch_o.tok[SLOT_SYM] = run_token(mode_d, kwok_d, kwp_d, line_d, start_d, len_d);
      end
      batch_o.vld[SLOT_EOF] = 1'b1;
      batch_o.tok[SLOT_EOF] = make_token(TK_EOF, FIELD_W'(line_d), FIELD_W'(col_d), '0,
                                         CH_NUL);
      mode_d  = MODE_IDLE;
      line_d  = CntOne;
      col_d   = CntOne;
      start_d = '0;
      len_d   = '0;
      kwp_d   = 3'd0;
      kwok_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      line_q  <= CntOne;
      col_q   <= CntOne;
      start_q <= '0;
      len_q   <= '0;
      kwp_q   <= 3'd0;
      kwok_q  <= 1'b1;
    end else if (step_i) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      start_q <= start_d;
      len_q   <= len_d;
      kwp_q   <= kwp_d;
      kwok_q  <= kwok_d;
    end
  end

endmodule

// ----- hw/rtl/etl_emit.sv -----
// Result register that holds one byte's tokens and hands them out one beat at a time.
module etl_emit import etl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  tok_batch_t batch_i,
  output logic       ready_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_beat_t  out_beat_o
);

  logic [MAX_TOKENS-1:0]      vld_q, vld_d;
  out_beat_t [MAX_TOKENS-1:0] tok_q;
  logic [MAX_TOKENS-1:0]      head;
  logic [MAX_TOKENS-1:0]      rest;
  logic [1:0]                 sel;
  logic                       pop;

  // Oldest pending slot goes first.
  always_comb begin
    priority if (vld_q[SLOT_RUN]) begin
      sel = 2'(SLOT_RUN);
    end else if (vld_q[SLOT_SYM]) begin
      sel = 2'(SLOT_SYM);
    end else begin
      sel = 2'(SLOT_EOF);
    end
    head      = '0;
    head[sel] = 1'b1;
  end

  assign rest        = vld_q & ~head;
  assign out_valid_o = |vld_q;
  assign pop         = out_valid_o && !out_stall_i;
  assign ready_o     = (vld_q == '0) || (pop && (rest == '0));

  always_comb begin
    out_beat_o             = tok_q[sel];
    out_beat_o.last_of_run = (rest == '0);
  end

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = batch_i.vld;
    end else if (pop) begin
      vld_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tok_q <= batch_i.tok;
    end
  end

endmodule

// ----- hw/rtl/expression_token_lexer.sv -----
// Top level of the expression token lexer: input register, scanner and result register.
//
//   channel | direction | handshake                 | beat
//   --------+-----------+---------------------------+-----------------------------
//   in      | to block  | in_valid_i / in_stall_o   | in_beat_t: one source byte
//   out     | from block| out_valid_o / out_stall_i | out_beat_t: one token
//
// A byte is scanned while it waits in the input register; its tokens land in the result
// register as the byte advances, and the first token is offered from there.
// A byte that yields zero or one token frees the path every cycle unless the output stalls;
// a byte with more holds it until its last token goes; the output moves one token per beat.
// Reset clears the scanner to line 1, column 1, idle, and empties both registers.
// A stalled output holds its token; the input stalls only while the input register
// is full and the result register cannot take its tokens this cycle.
module expression_token_lexer import etl_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  `include "assert_macros.svh"

  logic       in_vld_q, in_vld_d;
  in_beat_t   in_q;
  logic       in_take;
  logic       emit_ready;
  logic       advance;
  tok_batch_t batch;

  // Advance the held byte whenever the result register frees up this cycle.
  assign advance    = in_vld_q && emit_ready;
  assign in_stall_o = in_vld_q && !emit_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Payload register: load on acceptance, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_beat_i;
    end
  end

  // Scanner state advances exactly once per byte, as it moves into the result register.
  etl_scan #(
    .CounterWidth(COUNTER_WIDTH)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .beat_i (in_q),
    .batch_o(batch)
  );

  etl_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .batch_i    (batch),
    .ready_o    (emit_ready),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  // Input only stalls when a byte is waiting in the input register.
  `ETL_ASSERT(a_stall_needs_byte, in_stall_o |-> in_vld_q, "input stalled while empty")
  // The end-of-source token is always the final token of its byte.
  `ETL_ASSERT(a_eof_is_last, (out_valid_o && (out_beat_o.token_kind == TK_EOF)) |->
              out_beat_o.last_of_run, "eof token not last of its byte")
  // No token is offered while reset is applied.
  `ETL_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "token offered in reset")

endmodule
